### src/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; included by stage_split_index_remap_core, which checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### src/ssir_pkg.sv
// types and constants for the stage split index remap block
// no dependencies; used by ssir_remap_mem, stage_split_index_remap_core and the verif files
package ssir_pkg;

   localparam int MAX_PARTS = 256;
   localparam int MAX_LINKS = 1024;

   localparam int PART_AW  = $clog2(MAX_PARTS);   // remap table address bits
   localparam int COUNT_W  = PART_AW + 1;         // holds 0..MAX_PARTS
   localparam int LINK_W   = $clog2(MAX_LINKS);   // link ordinal bits
   localparam int INDEX_W  = 10;                  // item_index word width
   localparam int END_W    = 8;                   // endpoint and new index width

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_PART  = 2'd1,
      OP_LINK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   // one remap table entry: kept mark plus compacted index
   typedef struct packed {
      logic             kept;
      logic [END_W-1:0] new_index;
   } remap_entry_type;

   // write port of the remap table
   typedef struct packed {
      logic               en;
      logic [PART_AW-1:0] addr;
      remap_entry_type    data;
   } remap_wr_type;

endpackage

### src/stage_split_index_remap_core.sv
// top level of the stage split index remap block
// depends on ssir_pkg, ssir_remap_mem and assert_macros.svh
//
//   channel   handshake              words
//   -------   ---------------------  ----------------------------------------
//   request   start / busy           req_operation req_drop_flag req_end_a/b
//   response  rsp_valid (strobe)     rsp_item_index rsp_kept rsp_new_a/b
//                                    rsp_error_code
//
// one request word per cycle while busy is low; a part or link gives its response word
// through the first stage register with the remap table read, then the response register
// busy is high during reset and for the cycle after it; counters clear in reset,
// the remap table is not cleared and is valid only where written
// the response side has no stall: each response word shows for one cycle
`include "assert_macros.svh"

module stage_split_index_remap_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_operation,
   input  logic                         req_drop_flag,
   input  logic [ssir_pkg::END_W-1:0]   req_end_a,
   input  logic [ssir_pkg::END_W-1:0]   req_end_b,
   output logic                         rsp_valid,
   output logic [ssir_pkg::INDEX_W-1:0] rsp_item_index,
   output logic                         rsp_kept,
   output logic [ssir_pkg::END_W-1:0]   rsp_new_a,
   output logic [ssir_pkg::END_W-1:0]   rsp_new_b,
   output logic [1:0]                   rsp_error_code
);
   import ssir_pkg::*;

   // ---------------------------------------------------------------- control
   logic   busy_ff;
   logic   accept;
   op_type op;

   assign accept = start && !busy_ff;
   assign op     = op_type'(req_operation);
   assign busy   = busy_ff;

   // held through the cycle after reset so nothing enters with the counters settling
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   // ---------------------------------------------------------------- counters
   logic [COUNT_W-1:0] parts_loaded_ff, parts_loaded_in;
   logic [COUNT_W-1:0] kept_count_ff,   kept_count_in;
   logic [LINK_W-1:0]  link_ordinal_ff, link_ordinal_in;

   logic table_full;
   logic range_err;

   assign table_full = (parts_loaded_ff == COUNT_W'(MAX_PARTS));
   // an endpoint at or beyond the loaded part count is out of range
   assign range_err  = ({1'b0, req_end_a} >= parts_loaded_ff) ||
                       ({1'b0, req_end_b} >= parts_loaded_ff);

   // ------------------------------------------------------- first stage word
   logic                  s1_valid_ff,  s1_valid_in;
   logic                  s1_link_ff,   s1_link_in;
   logic [INDEX_W-1:0]    s1_index_ff,  s1_index_in;
   logic                  s1_kept_ff,   s1_kept_in;
   logic [END_W-1:0]      s1_new_a_ff,  s1_new_a_in;
   err_type               s1_err_ff,    s1_err_in;

   remap_wr_type          wr;
   remap_entry_type       rd_a;
   remap_entry_type       rd_b;

   always_comb begin
      parts_loaded_in = parts_loaded_ff;
      kept_count_in   = kept_count_ff;
      link_ordinal_in = link_ordinal_ff;
      s1_valid_in     = 1'b0;
      s1_link_in      = 1'b0;
      s1_index_in     = INDEX_W'(parts_loaded_ff);
      s1_kept_in      = 1'b0;
      s1_new_a_in     = '0;
      s1_err_in       = ERR_OK;
      wr.en           = 1'b0;
      wr.addr         = parts_loaded_ff[PART_AW-1:0];
      wr.data.kept    = !req_drop_flag;
      wr.data.new_index = req_drop_flag ? '0 : kept_count_ff[END_W-1:0];
      if (accept) begin
         case (op)
            OP_START: begin
               parts_loaded_in = '0;
               kept_count_in   = '0;
               link_ordinal_in = '0;
            end
            OP_PART: begin
               s1_valid_in = 1'b1;
               if (table_full) begin
                  // full table: flag only, counters stay
                  s1_err_in = ERR_FULL;
               end else begin
                  wr.en           = 1'b1;
                  parts_loaded_in = parts_loaded_ff + 1'b1;
                  if (!req_drop_flag) begin
                     s1_kept_in    = 1'b1;
                     s1_new_a_in   = kept_count_ff[END_W-1:0];
                     kept_count_in = kept_count_ff + 1'b1;
                  end
               end
            end
            OP_LINK: begin
               s1_valid_in = 1'b1;
               s1_link_in  = 1'b1;
               s1_index_in = INDEX_W'(link_ordinal_ff);
               // ordinal wraps after the last link slot
               link_ordinal_in = (link_ordinal_ff == LINK_W'(MAX_LINKS - 1)) ?
                                 '0 : link_ordinal_ff + 1'b1;
               if (range_err) begin
                  s1_err_in = ERR_RANGE;
               end
            end
            default: begin
               // unused code: no state change, no response
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parts_loaded_ff <= '0;
         kept_count_ff   <= '0;
         link_ordinal_ff <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         parts_loaded_ff <= parts_loaded_in;
         kept_count_ff   <= kept_count_in;
         link_ordinal_ff <= link_ordinal_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_link_ff  <= s1_link_in;
      s1_index_ff <= s1_index_in;
      s1_kept_ff  <= s1_kept_in;
      s1_new_a_ff <= s1_new_a_in;
      s1_err_ff   <= s1_err_in;
   end

   // table reads go out at the link's accept edge; a part written at an
   // earlier edge is already in the array, so no forwarding is needed
   ssir_remap_mem u_remap_mem (
      .clock     (clock),
      .wr        (wr),
      .rd_addr_a (req_end_a[PART_AW-1:0]),
      .rd_addr_b (req_end_b[PART_AW-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // ------------------------------------------------------- response word
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_kept_ff,  rsp_kept_in;
   logic [END_W-1:0]   rsp_new_a_ff, rsp_new_a_in;
   logic [END_W-1:0]   rsp_new_b_ff, rsp_new_b_in;
   err_type            rsp_err_ff;

   always_comb begin
      rsp_kept_in  = s1_kept_ff;
      rsp_new_a_in = s1_new_a_ff;
      rsp_new_b_in = '0;
      if (s1_link_ff) begin
         // kept only if in range and both ends carry the kept mark
         if ((s1_err_ff == ERR_OK) && rd_a.kept && rd_b.kept) begin
            rsp_kept_in  = 1'b1;
            rsp_new_a_in = rd_a.new_index;
            rsp_new_b_in = rd_b.new_index;
         end else begin
            rsp_kept_in  = 1'b0;
            rsp_new_a_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= s1_index_ff;
      rsp_kept_ff  <= rsp_kept_in;
      rsp_new_a_ff <= rsp_new_a_in;
      rsp_new_b_ff <= rsp_new_b_in;
      rsp_err_ff   <= s1_err_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_index = rsp_index_ff;
   assign rsp_kept       = rsp_kept_ff;
   assign rsp_new_a      = rsp_new_a_ff;
   assign rsp_new_b      = rsp_new_b_ff;
   assign rsp_error_code = rsp_err_ff;

   // ------------------------------------------------------- checks
   `ASSERT_NEXT(a_s1_to_rsp, clock, reset, s1_valid_ff, rsp_valid_ff)
   `ASSERT_IMPL(a_err_not_kept, clock, reset, rsp_valid_ff && (rsp_err_ff != ERR_OK),
                !rsp_kept_ff && (rsp_new_a_ff == '0) && (rsp_new_b_ff == '0))
   `ASSERT_NEXT(a_start_clears, clock, reset, accept && (op == OP_START),
                (parts_loaded_ff == '0) && (kept_count_ff == '0) && (link_ordinal_ff == '0))
   `ASSERT_NEXT(a_full_holds, clock, reset, accept && (op == OP_PART) && table_full,
                $stable(parts_loaded_ff) && $stable(kept_count_ff))

endmodule

### src/ssir_remap_mem.sv
// remap table: one write port, two read ports, registered read data
// depends on ssir_pkg
module ssir_remap_mem (
   input  logic                          clock,
   input  ssir_pkg::remap_wr_type        wr,
   input  logic [ssir_pkg::PART_AW-1:0]  rd_addr_a,
   input  logic [ssir_pkg::PART_AW-1:0]  rd_addr_b,
   output ssir_pkg::remap_entry_type     rd_data_a,
   output ssir_pkg::remap_entry_type     rd_data_b
);
   import ssir_pkg::*;

   remap_entry_type mem [MAX_PARTS];
   remap_entry_type rd_a_ff;
   remap_entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read-before-write on a shared edge
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### verif/ssir_remap_checker.sv
// scoreboard for the stage split index remap block: predicts each response word and compares
// depends on ssir_pkg; instantiated beside the block by tb_stage_split_index_remap_core
`timescale 1ns / 100ps

module ssir_remap_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [1:0]                   req_operation,
   input  logic                         req_drop_flag,
   input  logic [ssir_pkg::END_W-1:0]   req_end_a,
   input  logic [ssir_pkg::END_W-1:0]   req_end_b,
   input  logic                         rsp_valid,
   input  logic [ssir_pkg::INDEX_W-1:0] rsp_item_index,
   input  logic                         rsp_kept,
   input  logic [ssir_pkg::END_W-1:0]   rsp_new_a,
   input  logic [ssir_pkg::END_W-1:0]   rsp_new_b,
   input  logic [1:0]                   rsp_error_code,
   output int                           mismatches,
   output int                           words_due
);
   import ssir_pkg::*;

   localparam int REPORT_CAP = 200;

   typedef struct packed {
      logic [INDEX_W-1:0] item_index;
      logic               kept;
      logic [END_W-1:0]   new_a;
      logic [END_W-1:0]   new_b;
      logic [1:0]         error_code;
   } remap_word_type;

   remap_entry_type    shadow_table [MAX_PARTS];
   logic [COUNT_W-1:0] parts_seen;
   logic [COUNT_W-1:0] kept_seen;
   logic [LINK_W-1:0]  next_link;
   remap_word_type     remap_words_due [$];
   remap_word_type     oldest;
   int                 reports;

   // updates the shadow counters and table, queues the response word if any
   function automatic void remap_request(input logic [1:0] op, input logic drop,
                                         input logic [END_W-1:0] ea,
                                         input logic [END_W-1:0] eb);
      remap_word_type  w;
      remap_entry_type ra;
      remap_entry_type rb;
      w = '0;
      case (op)
         OP_START: begin
            parts_seen = '0;
            kept_seen  = '0;
            next_link  = '0;
         end
         OP_PART: begin
            w.item_index = INDEX_W'(parts_seen);
            if (parts_seen >= COUNT_W'(MAX_PARTS)) begin
               w.error_code = ERR_FULL;
            end else begin
               if (drop) begin
                  shadow_table[parts_seen[PART_AW-1:0]] = '0;
               end else begin
                  w.kept  = 1'b1;
                  w.new_a = kept_seen[END_W-1:0];
                  shadow_table[parts_seen[PART_AW-1:0]] = {1'b1, kept_seen[END_W-1:0]};
                  kept_seen = kept_seen + 1'b1;
               end
               parts_seen = parts_seen + 1'b1;
            end
            remap_words_due = {remap_words_due, w};
         end
         OP_LINK: begin
            w.item_index = INDEX_W'(next_link);
            next_link = (int'(next_link) + 1 >= MAX_LINKS) ? '0 : next_link + 1'b1;
            if (ea >= parts_seen || eb >= parts_seen) begin
               w.error_code = ERR_RANGE;
            end else begin
               ra = shadow_table[ea];
               rb = shadow_table[eb];
               if (ra.kept && rb.kept) begin
                  w.kept  = 1'b1;
                  w.new_a = ra.new_index;
                  w.new_b = rb.new_index;
               end
            end
            remap_words_due = {remap_words_due, w};
         end
         default: ;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (reports < REPORT_CAP) begin
            reports++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         end
      end
   endtask

   // request side first, so a response in the same cycle as its request would still find its word
   always @(posedge clock) begin
      if (reset) begin
         parts_seen = '0;
         kept_seen  = '0;
         next_link  = '0;
         remap_words_due.delete();
         mismatches = 0;
         reports    = 0;
      end else begin
         if (start && !busy)
            remap_request(req_operation, req_drop_flag, req_end_a, req_end_b);
         if (rsp_valid) begin
            if (remap_words_due.size() == 0) begin
               mismatches++;
               if (reports < REPORT_CAP) begin
                  reports++;
                  $display("%0t: response word expected none actual index %0d",
                           $time, rsp_item_index);
               end
            end else begin
               oldest = remap_words_due.pop_front();
               check_field("item_index", 16'(oldest.item_index), 16'(rsp_item_index));
               check_field("kept", 16'(oldest.kept), 16'(rsp_kept));
               check_field("new_a", 16'(oldest.new_a), 16'(rsp_new_a));
               check_field("new_b", 16'(oldest.new_b), 16'(rsp_new_b));
               check_field("error_code", 16'(oldest.error_code), 16'(rsp_error_code));
            end
         end
      end
      words_due <= remap_words_due.size();
   end

endmodule

### verif/tb_stage_split_index_remap_core.sv
// testbench top for stage_split_index_remap_core: drives request words, gives the verdict
// depends on ssir_pkg, stage_split_index_remap_core and ssir_remap_checker
`timescale 1ns / 100ps

module tb_stage_split_index_remap_core;
   import ssir_pkg::*;

   // the fourth operation code has no meaning; the block must ignore it
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 1900;
   // no idling once this few items remain
   localparam int QUIET_TAIL  = 150;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_operation;
   logic               req_drop_flag;
   logic [END_W-1:0]   req_end_a;
   logic [END_W-1:0]   req_end_b;
   logic               rsp_valid;
   logic [INDEX_W-1:0] rsp_item_index;
   logic               rsp_kept;
   logic [END_W-1:0]   rsp_new_a;
   logic [END_W-1:0]   rsp_new_b;
   logic [1:0]         rsp_error_code;

   int mismatches;
   int words_due;
   int items_sent;
   // chance out of 16 that an idle burst comes before a word
   int gap_odds;
   // rough count of parts loaded since the last start, only to aim endpoints
   int parts_loaded_guess;

   stage_split_index_remap_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_drop_flag  (req_drop_flag),
      .req_end_a      (req_end_a),
      .req_end_b      (req_end_b),
      .rsp_valid      (rsp_valid),
      .rsp_item_index (rsp_item_index),
      .rsp_kept       (rsp_kept),
      .rsp_new_a      (rsp_new_a),
      .rsp_new_b      (rsp_new_b),
      .rsp_error_code (rsp_error_code)
   );

   ssir_remap_checker remap_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_drop_flag  (req_drop_flag),
      .req_end_a      (req_end_a),
      .req_end_b      (req_end_b),
      .rsp_valid      (rsp_valid),
      .rsp_item_index (rsp_item_index),
      .rsp_kept       (rsp_kept),
      .rsp_new_a      (rsp_new_a),
      .rsp_new_b      (rsp_new_b),
      .rsp_error_code (rsp_error_code),
      .mismatches     (mismatches),
      .words_due      (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // one request word: optional idle burst, then hold start until busy is low at an edge
   // start is never lowered in the step where it is raised again
   task automatic send_word(input logic [1:0] op, input logic drop,
                            input logic [END_W-1:0] ea, input logic [END_W-1:0] eb);
      if (gap_odds != 0 && items_sent < ITEM_TARGET - QUIET_TAIL &&
          $urandom_range(0, 15) < gap_odds) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_drop_flag <= drop;
      req_end_a     <= ea;
      req_end_b     <= eb;
      // busy read right after the edge is its value during the cycle that ended
      @(posedge clock);
      while (busy) @(posedge clock);
      case (op)
         OP_START: parts_loaded_guess = 0;
         OP_PART:  if (parts_loaded_guess < MAX_PARTS) parts_loaded_guess++;
         default: ;
      endcase
      if (op != OP_UNUSED) items_sent++;
   endtask

   // sender holds off until every response word has come back
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (words_due != 0);
   endtask

   task automatic send_part(input logic drop);
      send_word(OP_PART, drop, END_W'($urandom), END_W'($urandom));
   endtask

   task automatic send_link(input logic [END_W-1:0] ea, input logic [END_W-1:0] eb);
      send_word(OP_LINK, 1'($urandom), ea, eb);
   endtask

   task automatic send_start();
      send_word(OP_START, 1'($urandom), END_W'($urandom), END_W'($urandom));
   endtask

   task automatic send_noise();
      send_word(OP_UNUSED, 1'($urandom), END_W'($urandom), END_W'($urandom));
   endtask

   // one split: usually a start, then parts, then links; some noise and misordering
   task automatic random_phase();
      int               n_parts;
      int               n_links;
      int               drop_pct;
      logic [END_W-1:0] ea;
      logic [END_W-1:0] eb;
      gap_odds = $urandom_range(0, 4);
      drop_pct = $urandom_range(0, 100);
      // skipping the start keeps counters running across splits
      if ($urandom_range(0, 7) != 0) send_start();
      // mostly small splits, now and then a large one that can fill the table
      n_parts = ($urandom_range(0, 15) == 0) ? $urandom_range(200, 260) : $urandom_range(0, 24);
      repeat (n_parts) begin
         if ($urandom_range(0, 19) == 0) send_noise();
         send_part($urandom_range(0, 99) < drop_pct);
      end
      n_links = $urandom_range(1, 40);
      repeat (n_links) begin
         // mostly endpoints inside the loaded range, some anywhere
         if (parts_loaded_guess != 0 && $urandom_range(0, 7) != 0) begin
            ea = END_W'($urandom_range(0, parts_loaded_guess - 1));
            eb = END_W'($urandom_range(0, parts_loaded_guess - 1));
         end else begin
            ea = END_W'($urandom);
            eb = END_W'($urandom);
         end
         // a late part between links
         if ($urandom_range(0, 24) == 0) send_part(1'($urandom));
         send_link(ea, eb);
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
   endtask

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_operation <= OP_START;
      req_drop_flag <= 1'b0;
      req_end_a     <= '0;
      req_end_b     <= '0;
      items_sent         = 0;
      gap_odds           = 3;
      parts_loaded_guess = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, kept and dropped parts, cut and kept links,
      // endpoints at and past the loaded count, ignored code, restart
      send_link(8'd0, 8'd0);             // nothing loaded yet: range error
      send_noise();
      send_start();
      send_word(OP_PART, 1'b0, 8'd0, 8'd0);
      send_word(OP_PART, 1'b1, 8'd0, 8'd0);
      send_word(OP_PART, 1'b0, 8'd255, 8'd255);
      send_word(OP_PART, 1'b0, 8'd255, 8'd0);
      send_link(8'd0, 8'd2);             // both kept
      send_link(8'd0, 8'd1);             // second end dropped: cut
      send_link(8'd3, 8'd3);
      send_link(8'd4, 8'd0);             // first end equal to parts loaded
      send_link(8'd0, 8'd4);
      send_link(8'd255, 8'd255);
      send_link(8'd255, 8'd0);
      send_noise();
      send_start();                      // counters clear, table keeps old entries
      send_link(8'd0, 8'd0);             // stale entry must not be seen
      send_word(OP_PART, 1'b1, 8'd255, 8'd255);
      send_word(OP_PART, 1'b0, 8'd255, 8'd255);
      send_link(8'd1, 8'd0);
      send_link(8'd1, 8'd1);
      wait_drained();

      // one long split: table fills and overflows, link ordinal wraps
      gap_odds = 2;
      send_start();
      repeat (MAX_PARTS + 4) send_part($urandom_range(0, 3) == 0);
      repeat (MAX_LINKS + 16) send_link(END_W'($urandom), END_W'($urandom));
      wait_drained();

      // every part kept, so the compacted index reaches its top value, back to back
      gap_odds = 0;
      send_start();
      repeat (MAX_PARTS + 1) send_part(1'b0);
      repeat (20) send_link(END_W'($urandom), END_W'($urandom));

      while (items_sent < ITEM_TARGET) random_phase();

      // drain, then keep the clock running to catch any stray response word
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && words_due == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/ssir_pkg.sv
src/ssir_remap_mem.sv
src/stage_split_index_remap_core.sv
verif/ssir_remap_checker.sv
verif/tb_stage_split_index_remap_core.sv
